// ===== rtl/skyline_atlas_allocator_top_assert.svh =====
// ----------------------------------------------------------------------------
// Skyline atlas allocator assertion macros
// Shared helpers for the concurrent checks. All checks sample on the rising
// edge of clk and are off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SKYLINE_ATLAS_ALLOCATOR_TOP_ASSERT_SVH
`define SKYLINE_ATLAS_ALLOCATOR_TOP_ASSERT_SVH

// Plain property check.
`define SAA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication.
`define SAA_ASSERT_IMP(lbl, ante, cons, msg) \
	`SAA_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define SAA_ASSERT_NXT(lbl, ante, cons, msg) \
	`SAA_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/saa_pkg.sv =====
// ----------------------------------------------------------------------------
// Skyline atlas allocator package
// Sizes, payload types and memory port bundles shared by the allocator files.
// ----------------------------------------------------------------------------
`default_nettype none

package saa_pkg;

	// Atlas geometry.
	localparam int ATLAS_COLUMNS = 1024;
	localparam int IDX_W = $clog2(ATLAS_COLUMNS);
	localparam int CNT_W = $clog2(ATLAS_COLUMNS + 1);
	localparam int E_W = IDX_W + 1;

	// Field widths of the channels.
	localparam int H_W = 11;
	localparam int WID_W = 11;
	localparam int POS_W = 10;
	localparam int CMP_W = (WID_W > CNT_W) ? WID_W : CNT_W;

	// Height limit after reset.
	localparam logic [H_W-1:0] LIMIT_RST = H_W'(512);

	// One result item.
	typedef struct packed {
		logic             success;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
	} res_t;

	// Write port of a column memory.
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		logic [H_W-1:0]   data;
	} mem_wr_t;

endpackage

`default_nettype wire

// ===== rtl/saa_if.sv =====
// ----------------------------------------------------------------------------
// Skyline atlas allocator channel interfaces
// Valid/ready channels for requests, results and the height limit register.
// ----------------------------------------------------------------------------
`default_nettype none

// Rectangle request channel.
interface saa_req_if;
	import saa_pkg::*;
	logic             valid;
	logic             ready;
	logic [WID_W-1:0] req_width;
	logic [H_W-1:0]   req_height;

	modport source (output valid, output req_width, output req_height, input ready);
	modport sink (input valid, input req_width, input req_height, output ready);
endinterface

// Placement result channel.
interface saa_res_if;
	import saa_pkg::*;
	logic             valid;
	logic             ready;
	logic             success;
	logic [POS_W-1:0] pos_x;
	logic [POS_W-1:0] pos_y;

	modport source (output valid, output success, output pos_x, output pos_y, input ready);
	modport sink (input valid, input success, input pos_x, input pos_y, output ready);
endinterface

// Height limit write channel.
interface saa_cfg_if;
	import saa_pkg::*;
	logic           valid;
	logic           ready;
	logic [H_W-1:0] height_limit;

	modport source (output valid, output height_limit, input ready);
	modport sink (input valid, input height_limit, output ready);
endinterface

`default_nettype wire

// ===== rtl/saa_ram.sv =====
// ----------------------------------------------------------------------------
// Skyline atlas allocator RAM
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module saa_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 11
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered read data.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/saa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Skyline atlas allocator sequencer
// Clears the skyline after reset, then for each request of usable width runs a
// prefix-max pass and a suffix-max pass over the columns to find the lowest
// window and, if the rectangle fits, writes the raised columns back.
// ----------------------------------------------------------------------------
`default_nettype none

module saa_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	saa_req_if.sink                     req,
	saa_cfg_if.sink                     cfg,
	output logic                        res_valid,
	input  wire logic                   res_ready,
	output saa_pkg::res_t               res_data,
	output saa_pkg::mem_wr_t            hmem_wr,
	output logic [saa_pkg::IDX_W-1:0]   hmem_raddr,
	input  wire logic [saa_pkg::H_W-1:0] hmem_rdata,
	output saa_pkg::mem_wr_t            pmem_wr,
	output logic [saa_pkg::IDX_W-1:0]   pmem_raddr,
	input  wire logic [saa_pkg::H_W-1:0] pmem_rdata
);

	import saa_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PASS1,
		ST_GAP,
		ST_PASS2,
		ST_DRAIN,
		ST_DECIDE,
		ST_WRITE,
		ST_RESULT
	} state_t;

	localparam logic [IDX_W-1:0] LAST_COL = IDX_W'(ATLAS_COLUMNS - 1);

	state_t           state_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] wm1_q;
	logic [H_W-1:0]   h_q;
	logic [H_W-1:0]   limit_q;
	logic [H_W-1:0]   run_q;
	logic [H_W-1:0]   best_q;
	logic [IDX_W-1:0] best_x_q;
	logic             found_q;
	res_t             res_q;

	logic             p1_s1;
	logic             p2_s1;
	logic [IDX_W-1:0] x_s1;
	logic [IDX_W-1:0] pos_s1;
	logic             win_s1;
	logic             first_s1;

	logic [E_W-1:0]   e_addr;
	logic [H_W-1:0]   run_max;
	logic [H_W-1:0]   pfx;
	logic [H_W-1:0]   sfx;
	logic [H_W-1:0]   run_nxt;
	logic [H_W-1:0]   win_max;
	logic             take;
	logic [H_W:0]     top_sum;
	logic             fit;
	logic             bad_width;

	// Window end column for the start column being issued.
	assign e_addr = E_W'(cnt_q) + E_W'(wm1_q);

	// Running block maximum: prefix in the first pass, suffix in the second.
	assign run_max = (hmem_rdata > run_q) ? hmem_rdata : run_q;
	assign pfx = (pos_s1 == '0) ? hmem_rdata : run_max;
	assign sfx = (first_s1 || (pos_s1 == wm1_q)) ? hmem_rdata : run_max;
	assign run_nxt = p1_s1 ? pfx : sfx;

	// Window maximum joins the suffix of its first block and prefix of its last.
	assign win_max = (sfx > pmem_rdata) ? sfx : pmem_rdata;
	assign take = p2_s1 && win_s1 &&
		((win_max < best_q) || (found_q && (win_max == best_q)));

	// Fit test on the chosen base.
	assign top_sum = {1'b0, best_q} + {1'b0, h_q};
	assign fit = found_q && (top_sum <= {1'b0, limit_q});

	// Widths of zero or beyond the atlas fail at once.
	assign bad_width = (req.req_width == '0) ||
		(CMP_W'(req.req_width) > CMP_W'(ATLAS_COLUMNS));

	// Handshakes.
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign res_valid = (state_q == ST_RESULT);
	assign res_data = res_q;

	// Memory read addresses.
	assign hmem_raddr = cnt_q;
	assign pmem_raddr = e_addr[IDX_W-1:0];

	// Prefix memory is written from the first-pass stage.
	assign pmem_wr = '{we: p1_s1, addr: x_s1, data: pfx};

	// Skyline write port: clearing pass or write-back of the placed columns.
	always_comb begin
		hmem_wr = '{we: 1'b0, addr: cnt_q, data: '0};
		unique case (state_q)
			ST_CLEAR: begin
				hmem_wr = '{we: 1'b1, addr: cnt_q, data: '0};
			end
			ST_WRITE: begin
				hmem_wr = '{we: 1'b1, addr: best_x_q + cnt_q, data: top_sum[H_W-1:0]};
			end
			default: begin
				hmem_wr = '{we: 1'b0, addr: cnt_q, data: '0};
			end
		endcase
	end

	// Sequencer, scan stage and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			cnt_q    <= '0;
			pos_q    <= '0;
			wm1_q    <= '0;
			h_q      <= '0;
			limit_q  <= LIMIT_RST;
			run_q    <= '0;
			best_q   <= '0;
			best_x_q <= '0;
			found_q  <= 1'b0;
			res_q    <= '0;
			p1_s1    <= 1'b0;
			p2_s1    <= 1'b0;
			x_s1     <= '0;
			pos_s1   <= '0;
			win_s1   <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			// Height limit register.
			if (cfg.valid) begin
				limit_q <= cfg.height_limit;
			end

			// Scan stage follows the read issued in the previous cycle.
			p1_s1    <= (state_q == ST_PASS1);
			p2_s1    <= (state_q == ST_PASS2);
			x_s1     <= cnt_q;
			pos_s1   <= pos_q;
			win_s1   <= (e_addr <= E_W'(ATLAS_COLUMNS - 1));
			first_s1 <= (cnt_q == LAST_COL);
			if (p1_s1 || p2_s1) begin
				run_q <= run_nxt;
			end
			if (take) begin
				best_q   <= win_max;
				best_x_q <= x_s1;
				found_q  <= 1'b1;
			end

			unique case (state_q)
				ST_CLEAR: begin
					// The counter wraps to zero after the last column.
					cnt_q <= cnt_q + IDX_W'(1);
					if (cnt_q == LAST_COL) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						h_q     <= req.req_height;
						wm1_q   <= IDX_W'(req.req_width - WID_W'(1));
						best_q  <= limit_q;
						found_q <= 1'b0;
						cnt_q   <= '0;
						pos_q   <= '0;
						if (bad_width) begin
							res_q   <= '0;
							state_q <= ST_RESULT;
						end else begin
							state_q <= ST_PASS1;
						end
					end
				end
				ST_PASS1: begin
					cnt_q <= cnt_q + IDX_W'(1);
					pos_q <= (pos_q == wm1_q) ? '0 : pos_q + IDX_W'(1);
					if (cnt_q == LAST_COL) begin
						state_q <= ST_GAP;
					end
				end
				ST_GAP: begin
					// Last prefix write lands here; the second pass starts at the top.
					cnt_q   <= LAST_COL;
					pos_q   <= pos_s1;
					state_q <= ST_PASS2;
				end
				ST_PASS2: begin
					cnt_q <= cnt_q - IDX_W'(1);
					pos_q <= (pos_q == '0) ? wm1_q : pos_q - IDX_W'(1);
					if (cnt_q == '0) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					cnt_q <= '0;
					if (fit) begin
						state_q <= ST_WRITE;
					end else begin
						res_q   <= '0;
						state_q <= ST_RESULT;
					end
				end
				ST_WRITE: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if (cnt_q == wm1_q) begin
						res_q   <= '{success: 1'b1, pos_x: POS_W'(best_x_q),
							pos_y: POS_W'(best_q)};
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/skyline_atlas_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Skyline atlas allocator
// Skyline rectangle packer: keeps one filled height per atlas column and
// places each requested rectangle in the leftmost lowest window that fits.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Fields                      Accept
//   req      in   req_width, req_height       valid & ready
//   res      out  success, pos_x, pos_y       valid & ready
//   cfg      in   height_limit                valid & ready (ready always 1)
//
// An item with a usable width makes two full passes over the column memory,
// one read per cycle, and a placed rectangle's columns are then written back; a
// zero or oversized width skips the passes and fails at once. After reset a
// clearing pass over all ATLAS_COLUMNS columns zeroes the skyline while
// req.ready stays low. An output register holds one finished result, so the
// next item is taken while it waits.
`default_nettype none

module skyline_atlas_allocator_top (
	input  wire logic clk,
	input  wire logic arst_n,
	saa_req_if.sink   req,
	saa_res_if.source res,
	saa_cfg_if.sink   cfg
);

	import saa_pkg::*;

	logic             ctl_valid;
	logic             ctl_ready;
	res_t             ctl_res;
	mem_wr_t          hmem_wr;
	mem_wr_t          pmem_wr;
	logic [IDX_W-1:0] hmem_raddr;
	logic [IDX_W-1:0] pmem_raddr;
	logic [H_W-1:0]   hmem_rdata;
	logic [H_W-1:0]   pmem_rdata;
	logic             out_vld_q;
	res_t             out_q;

	// Sequencer.
	saa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg),
		.res_valid  (ctl_valid),
		.res_ready  (ctl_ready),
		.res_data   (ctl_res),
		.hmem_wr    (hmem_wr),
		.hmem_raddr (hmem_raddr),
		.hmem_rdata (hmem_rdata),
		.pmem_wr    (pmem_wr),
		.pmem_raddr (pmem_raddr),
		.pmem_rdata (pmem_rdata)
	);

	// Skyline column heights.
	saa_ram #(
		.DEPTH (ATLAS_COLUMNS),
		.WIDTH (H_W)
	) u_height_ram (
		.clk   (clk),
		.we    (hmem_wr.we),
		.waddr (hmem_wr.addr),
		.wdata (hmem_wr.data),
		.raddr (hmem_raddr),
		.rdata (hmem_rdata)
	);

	// Block prefix maxima of the current scan.
	saa_ram #(
		.DEPTH (ATLAS_COLUMNS),
		.WIDTH (H_W)
	) u_prefix_ram (
		.clk   (clk),
		.we    (pmem_wr.we),
		.waddr (pmem_wr.addr),
		.wdata (pmem_wr.data),
		.raddr (pmem_raddr),
		.rdata (pmem_rdata)
	);

	// Output register between the sequencer and the result channel.
	assign ctl_ready = !out_vld_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_q     <= '0;
		end else begin
			if (ctl_valid && ctl_ready) begin
				out_vld_q <= 1'b1;
				out_q     <= ctl_res;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign res.valid   = out_vld_q;
	assign res.success = out_q.success;
	assign res.pos_x   = out_q.pos_x;
	assign res.pos_y   = out_q.pos_y;

endmodule

`default_nettype wire

// ===== rtl/saa_checker.sv =====
// ----------------------------------------------------------------------------
// Skyline atlas allocator port checker
// Watches the top-level channels: result hold, failure encoding and the
// count of items in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "skyline_atlas_allocator_top_assert.svh"

module saa_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      req_valid,
	input wire logic                      req_ready,
	input wire logic                      res_valid,
	input wire logic                      res_ready,
	input wire logic                      res_success,
	input wire logic [saa_pkg::POS_W-1:0] res_pos_x,
	input wire logic [saa_pkg::POS_W-1:0] res_pos_y
);

	logic [1:0] pend_q;

	// Items accepted whose result is not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= pend_q + 2'(req_valid && req_ready) - 2'(res_valid && res_ready);
		end
	end

	// A waiting result stays offered.
	`SAA_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")

	// A failed placement reports zero coordinates.
	`SAA_ASSERT_IMP(a_fail_zero, res_valid && !res_success, res_pos_x == '0 && res_pos_y == '0, "failure with nonzero position")

	// Every delivered result belongs to an accepted item.
	`SAA_ASSERT_IMP(a_no_orphan, res_valid && res_ready, pend_q != 2'd0, "result without a request")

	// At most one item at work and one result waiting.
	`SAA_ASSERT(a_pend_max, pend_q != 2'd3, "too many items in flight")

endmodule

bind skyline_atlas_allocator_top saa_checker u_saa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_success (res.success),
	.res_pos_x   (res.pos_x),
	.res_pos_y   (res.pos_y)
);

`default_nettype wire
